/* hdl/ds402_drive_enable_sequencer_assert.svh */
// Assertion macros for the DS402 drive enable sequencer checker.
// Depends on nothing; included by the checker file.
`ifndef DS402_DRIVE_ENABLE_SEQUENCER_ASSERT_SVH
`define DS402_DRIVE_ENABLE_SEQUENCER_ASSERT_SVH

// Implication in the same cycle.
`define DSEN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dsen assertion failed");

// Implication into the next cycle.
`define DSEN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dsen assertion failed");

`endif

/* hdl/dsen_pkg.sv */
// Package for the DS402 drive enable sequencer: payload types, codes,
// status and control word values, and register map. No dependencies.
package dsen_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int TIME_BITS_MAX     = 64;
    localparam int DATA_BITS         = 32;
    localparam int ADDR_BITS         = 4;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_FAULT_TOGGLE = 2'd0;
    localparam logic [1:0] REG_SETTLE       = 2'd1;
    localparam logic [1:0] REG_RESET_HOLD   = 2'd2;
    localparam logic [1:0] REG_ENABLE_TMO   = 2'd3;

    localparam logic [31:0] RST_FAULT_TOGGLE = 32'd50000;
    localparam logic [31:0] RST_SETTLE       = 32'd100000;
    localparam logic [31:0] RST_RESET_HOLD   = 32'd10000;
    localparam logic [31:0] RST_ENABLE_TMO   = 32'd1000000;

    // Request codes carried in the mode field.
    localparam logic [1:0] MODE_UPDATE  = 2'd0;
    localparam logic [1:0] MODE_ENABLE  = 2'd1;
    localparam logic [1:0] MODE_DISABLE = 2'd2;

    // Statusword masks.
    localparam logic [15:0] ST_FAULT = 16'h0008;
    localparam logic [15:0] ST_READY = 16'h0021;
    localparam logic [15:0] ST_ON    = 16'h0027;
    localparam logic [15:0] ST_OFF   = 16'h0040;

    // Controlword values.
    localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
    localparam logic [15:0] CW_DISABLE_V   = 16'h0000;
    localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
    localparam logic [15:0] CW_NEUTRAL     = 16'h0000;

    typedef enum logic [2:0] {
        SEQ_OFF        = 3'd0,
        SEQ_SAFE_RESET = 3'd1,
        SEQ_PREPARE    = 3'd2,
        SEQ_SWITCH_ON  = 3'd3,
        SEQ_ON         = 3'd4,
        SEQ_FAULT      = 3'd5
    } t_seq_state;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2
    } t_command;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] drive_status;
        logic [31:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic [15:0] control_word;
        logic [2:0]  drive_state;
        logic [1:0]  active_command;
    } t_out_item;

    typedef struct packed {
        logic [31:0] fault_toggle_half_period;
        logic [31:0] settle_delay;
        logic [31:0] reset_hold_delay;
        logic [31:0] enable_timeout;
    } t_cfg;

endpackage

/* hdl/dsen_regs.sv */
// Configuration register file of the DS402 drive enable sequencer,
// written and read over an APB-style port. Depends on dsen_pkg.
module dsen_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsen_pkg::ADDR_BITS-1:0] paddr,
    input  logic [dsen_pkg::DATA_BITS-1:0] pwdata,
    output logic [dsen_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output dsen_pkg::t_cfg                o_cfg
);

    dsen_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fault_toggle_half_period <= dsen_pkg::RST_FAULT_TOGGLE;
            r_cfg.settle_delay             <= dsen_pkg::RST_SETTLE;
            r_cfg.reset_hold_delay         <= dsen_pkg::RST_RESET_HOLD;
            r_cfg.enable_timeout           <= dsen_pkg::RST_ENABLE_TMO;
        end else if (wr_en) begin
            case (reg_idx)
                dsen_pkg::REG_FAULT_TOGGLE: r_cfg.fault_toggle_half_period <= pwdata;
                dsen_pkg::REG_SETTLE:       r_cfg.settle_delay             <= pwdata;
                dsen_pkg::REG_RESET_HOLD:   r_cfg.reset_hold_delay         <= pwdata;
                dsen_pkg::REG_ENABLE_TMO:   r_cfg.enable_timeout           <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dsen_pkg::REG_FAULT_TOGGLE: prdata = r_cfg.fault_toggle_half_period;
            dsen_pkg::REG_SETTLE:       prdata = r_cfg.settle_delay;
            dsen_pkg::REG_RESET_HOLD:   prdata = r_cfg.reset_hold_delay;
            dsen_pkg::REG_ENABLE_TMO:   prdata = r_cfg.enable_timeout;
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/dsen_core.sv */
// Sequencer state and one-step update logic of the DS402 drive enable
// sequencer. Depends on dsen_pkg.
module dsen_core #(
    parameter int TIME_BITS = dsen_pkg::TIME_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  dsen_pkg::t_in_item  i_item,
    input  dsen_pkg::t_cfg      i_cfg,
    output dsen_pkg::t_out_item o_result
);

    dsen_pkg::t_command   r_command, n_command;
    dsen_pkg::t_seq_state r_seq_state, n_seq_state;
    logic                 r_had_fault, n_had_fault;
    logic                 r_settling, n_settling;
    logic                 r_reset_bit_on, n_reset_bit_on;
    logic [TIME_BITS-1:0] r_start_stamp, n_start_stamp;
    logic [TIME_BITS-1:0] r_toggle_stamp, n_toggle_stamp;
    logic [TIME_BITS-1:0] r_settle_stamp, n_settle_stamp;
    logic [15:0]          r_last_control, n_last_control;

    logic [dsen_pkg::TIME_BITS_MAX-1:0] now_ext;
    logic [TIME_BITS-1:0]               now;
    logic [TIME_BITS-1:0]               el_toggle, el_settle, el_start;
    logic                               faulted, toggle_due, settle_done;
    logic                               hold_done, timed_out;

    // The timestamp is taken modulo two to the TIME_BITS.
    assign now_ext   = dsen_pkg::TIME_BITS_MAX'(i_item.time_now);
    assign now       = now_ext[TIME_BITS-1:0];
    assign el_toggle = now - r_toggle_stamp;
    assign el_settle = now - r_settle_stamp;
    assign el_start  = now - r_start_stamp;

    assign faulted     = (i_item.drive_status & dsen_pkg::ST_FAULT) == dsen_pkg::ST_FAULT;
    assign toggle_due  = dsen_pkg::TIME_BITS_MAX'(el_toggle) >=
                         dsen_pkg::TIME_BITS_MAX'(i_cfg.fault_toggle_half_period);
    assign settle_done = dsen_pkg::TIME_BITS_MAX'(el_settle) >=
                         dsen_pkg::TIME_BITS_MAX'(i_cfg.settle_delay);
    assign hold_done   = dsen_pkg::TIME_BITS_MAX'(el_start) >
                         dsen_pkg::TIME_BITS_MAX'(i_cfg.reset_hold_delay);
    assign timed_out   = dsen_pkg::TIME_BITS_MAX'(el_start) >
                         dsen_pkg::TIME_BITS_MAX'(i_cfg.enable_timeout);

    always_comb begin
        n_command      = r_command;
        n_seq_state    = r_seq_state;
        n_had_fault    = r_had_fault;
        n_settling     = r_settling;
        n_reset_bit_on = r_reset_bit_on;
        n_start_stamp  = r_start_stamp;
        n_toggle_stamp = r_toggle_stamp;
        n_settle_stamp = r_settle_stamp;
        n_last_control = r_last_control;

        // A request only replaces the command; the unused code keeps it.
        if (i_item.mode == dsen_pkg::MODE_ENABLE) begin
            n_command = dsen_pkg::CMD_ENABLE;
        end else if (i_item.mode == dsen_pkg::MODE_DISABLE) begin
            n_command = dsen_pkg::CMD_DISABLE;
        end

        case (n_command)
            dsen_pkg::CMD_ENABLE: begin
                case (r_seq_state)
                    dsen_pkg::SEQ_OFF: begin
                        n_start_stamp = now;
                        if (faulted) begin
                            n_had_fault = 1'b1;
                            n_settling  = 1'b0;
                            if (toggle_due) begin
                                n_reset_bit_on = !r_reset_bit_on;
                                n_toggle_stamp = now;
                            end
                            n_last_control = n_reset_bit_on ? dsen_pkg::CW_FAULT_RESET
                                                            : dsen_pkg::CW_NEUTRAL;
                        end else if (r_had_fault) begin
                            n_last_control = dsen_pkg::CW_NEUTRAL;
                            if (!r_settling) begin
                                n_settling     = 1'b1;
                                n_settle_stamp = now;
                            end else if (settle_done) begin
                                n_seq_state = dsen_pkg::SEQ_SAFE_RESET;
                                n_had_fault = 1'b0;
                                n_settling  = 1'b0;
                            end
                        end else begin
                            n_seq_state = dsen_pkg::SEQ_SAFE_RESET;
                        end
                    end
                    dsen_pkg::SEQ_SAFE_RESET: begin
                        n_last_control = dsen_pkg::CW_SHUTDOWN;
                        if (hold_done) begin
                            n_seq_state = dsen_pkg::SEQ_PREPARE;
                        end
                    end
                    dsen_pkg::SEQ_PREPARE: begin
                        n_last_control = dsen_pkg::CW_SHUTDOWN;
                        if ((i_item.drive_status & dsen_pkg::ST_READY) == dsen_pkg::ST_READY) begin
                            n_seq_state = dsen_pkg::SEQ_SWITCH_ON;
                        end
                    end
                    dsen_pkg::SEQ_SWITCH_ON: begin
                        n_last_control = dsen_pkg::CW_ENABLE_OP;
                        if ((i_item.drive_status & dsen_pkg::ST_ON) == dsen_pkg::ST_ON) begin
                            n_seq_state = dsen_pkg::SEQ_ON;
                            n_command   = dsen_pkg::CMD_NONE;
                        end
                    end
                    dsen_pkg::SEQ_FAULT: begin
                        n_seq_state = dsen_pkg::SEQ_OFF;
                    end
                    default: ;
                endcase

                if (n_seq_state != dsen_pkg::SEQ_OFF && n_seq_state != dsen_pkg::SEQ_FAULT
                    && faulted) begin
                    n_seq_state = dsen_pkg::SEQ_OFF;
                end

                // Leaving OFF restarts the stamp at this step, so no timeout is
                // possible then; otherwise the stamp is unchanged.
                if (n_seq_state != dsen_pkg::SEQ_ON && n_seq_state != dsen_pkg::SEQ_FAULT
                    && n_seq_state != dsen_pkg::SEQ_OFF
                    && r_seq_state != dsen_pkg::SEQ_OFF && timed_out) begin
                    n_seq_state = dsen_pkg::SEQ_OFF;
                end
            end
            dsen_pkg::CMD_DISABLE: begin
                n_last_control = dsen_pkg::CW_DISABLE_V;
                if ((i_item.drive_status & dsen_pkg::ST_OFF) == dsen_pkg::ST_OFF) begin
                    n_seq_state = dsen_pkg::SEQ_OFF;
                    n_command   = dsen_pkg::CMD_NONE;
                end
            end
            default: begin
                if (faulted) begin
                    n_seq_state = dsen_pkg::SEQ_FAULT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command      <= dsen_pkg::CMD_NONE;
            r_seq_state    <= dsen_pkg::SEQ_OFF;
            r_had_fault    <= 1'b0;
            r_settling     <= 1'b0;
            r_reset_bit_on <= 1'b0;
            r_start_stamp  <= '0;
            r_toggle_stamp <= '0;
            r_settle_stamp <= '0;
            r_last_control <= '0;
        end else if (i_step) begin
            r_command      <= n_command;
            r_seq_state    <= n_seq_state;
            r_had_fault    <= n_had_fault;
            r_settling     <= n_settling;
            r_reset_bit_on <= n_reset_bit_on;
            r_start_stamp  <= n_start_stamp;
            r_toggle_stamp <= n_toggle_stamp;
            r_settle_stamp <= n_settle_stamp;
            r_last_control <= n_last_control;
        end
    end

    assign o_result.control_word   = n_last_control;
    assign o_result.drive_state    = n_seq_state;
    assign o_result.active_command = n_command;

endmodule

/* hdl/ds402_drive_enable_sequencer.sv */
// Top level of the DS402 drive enable sequencer: input register, output
// register and handshake. Depends on dsen_pkg, dsen_regs and dsen_core.
//
// The block turns one transaction per fieldbus cycle (request mode, drive
// statusword, timestamp) into the controlword to send, the sequence state
// and the active command. It takes one transaction every clock cycle while
// the output register is free: a transaction lands in an input register,
// and once the output register is free the sequencer state is updated and
// the result is loaded into the output register. The input register and the
// output register each hold one transaction, so while a result waits to be
// collected one more transaction is still taken if the input register is
// empty. Configuration registers are written over the APB port at byte
// addresses 0 (fault reset half period), 4 (settle delay), 8 (reset hold
// delay) and 12 (enable timeout); pready is always high. Timestamps are kept
// TIME_BITS wide, and elapsed times wrap modulo two to the TIME_BITS.
module ds402_drive_enable_sequencer #(
    parameter int TIME_BITS = dsen_pkg::TIME_BITS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dsen_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dsen_pkg::t_out_item            o_out_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dsen_pkg::ADDR_BITS-1:0] paddr,
    input  logic [dsen_pkg::DATA_BITS-1:0] pwdata,
    output logic [dsen_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);

    dsen_pkg::t_cfg      cfg;
    dsen_pkg::t_out_item step_result;

    logic                r_in_valid;
    dsen_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    dsen_pkg::t_out_item r_out_item;
    logic                out_free;
    logic                step;

    // The output register can take a result when empty or being drained.
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || step;

    dsen_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dsen_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // Input register: holds the accepted transaction until it is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // Output register: the result of the step taken in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* hdl/dsen_checker.sv */
// Port-level checker for the DS402 drive enable sequencer, bound to the top
// level. Depends on dsen_pkg and ds402_drive_enable_sequencer_assert.svh.
`include "ds402_drive_enable_sequencer_assert.svh"

module dsen_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dsen_pkg::t_out_item o_out_item
);

    logic out_stall;
    logic disabling;
    logic cw_is_disable;
    logic legal_word;

    assign out_stall     = o_out_valid && !i_out_ready;
    assign disabling     = o_out_valid && (o_out_item.active_command == dsen_pkg::CMD_DISABLE);
    assign cw_is_disable = o_out_item.control_word == dsen_pkg::CW_DISABLE_V;
    assign legal_word    = (o_out_item.control_word == dsen_pkg::CW_NEUTRAL)
                        || (o_out_item.control_word == dsen_pkg::CW_FAULT_RESET)
                        || (o_out_item.control_word == dsen_pkg::CW_SHUTDOWN)
                        || (o_out_item.control_word == dsen_pkg::CW_ENABLE_OP);

    // A result waiting for the consumer stays in place.
    `DSEN_ASSERT_NXT(a_out_valid_held, i_clk, i_rst_n, out_stall, o_out_valid)
    `DSEN_ASSERT_NXT(a_out_item_held, i_clk, i_rst_n, out_stall, $stable(o_out_item))

    // While a disable is pending the drive is always sent disable-voltage.
    `DSEN_ASSERT_IMP(a_disable_word, i_clk, i_rst_n, disabling, cw_is_disable)

    // Only the standard controlwords are ever produced.
    `DSEN_ASSERT_IMP(a_legal_word, i_clk, i_rst_n, o_out_valid, legal_word)

endmodule

bind ds402_drive_enable_sequencer dsen_checker u_dsen_checker (.*);

/* bench/ds402_drive_enable_sequencer_test.sv */
// Self-checking testbench for the DS402 drive enable sequencer. It holds a model
// of the sequencer, drives transactions under random flow control and checks results.
// Depends on dsen_pkg and the ds402_drive_enable_sequencer top level.
`timescale 1ns / 100ps

module ds402_drive_enable_sequencer_test;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam int TAIL_CYCLES   = 10;

    // The mode field has one code with no meaning; the block treats it as update only.
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_style;

    // Block ports.
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    dsen_pkg::t_in_item             i_in_item   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    dsen_pkg::t_out_item            o_out_item;
    logic                           psel        = 1'b0;
    logic                           penable     = 1'b0;
    logic                           pwrite      = 1'b0;
    logic [dsen_pkg::ADDR_BITS-1:0] paddr       = '0;
    logic [dsen_pkg::DATA_BITS-1:0] pwdata      = '0;
    logic [dsen_pkg::DATA_BITS-1:0] prdata;
    logic                           pready;

    ds402_drive_enable_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Sequencer model: a private copy of the command, the sequence state,
    // the fault bookkeeping, the three timestamps and the timing registers.
    // ------------------------------------------------------------------
    dsen_pkg::t_command   command_q;
    dsen_pkg::t_seq_state seq_q;
    logic                 had_fault_q;
    logic                 settling_q;
    logic                 reset_bit_q;
    logic [31:0]          start_stamp_q;
    logic [31:0]          toggle_stamp_q;
    logic [31:0]          settle_stamp_q;
    logic [15:0]          last_cw_q;
    dsen_pkg::t_cfg       timing_q;

    function automatic logic has_bits(input logic [15:0] sw, input logic [15:0] pattern);
        return (sw & pattern) == pattern;
    endfunction

    // Timestamps wrap, so elapsed time is a plain modulo subtraction.
    function automatic logic [31:0] ticks_since(input logic [31:0] now,
                                                input logic [31:0] stamp);
        return now - stamp;
    endfunction

    task automatic step_sequencer_model(input dsen_pkg::t_in_item req,
                                        output dsen_pkg::t_out_item res);
        logic        faulted;
        logic [31:0] now;
        now     = req.time_now;
        faulted = has_bits(req.drive_status, dsen_pkg::ST_FAULT);

        // A request only latches the command; the sequence itself is not touched.
        if (req.mode == dsen_pkg::MODE_ENABLE) begin
            command_q = dsen_pkg::CMD_ENABLE;
        end else if (req.mode == dsen_pkg::MODE_DISABLE) begin
            command_q = dsen_pkg::CMD_DISABLE;
        end

        case (command_q)
            dsen_pkg::CMD_ENABLE: begin
                case (seq_q)
                    dsen_pkg::SEQ_OFF: begin
                        start_stamp_q = now;
                        if (faulted) begin
                            // Acknowledge the drive fault by toggling fault reset.
                            had_fault_q = 1'b1;
                            settling_q  = 1'b0;
                            if (ticks_since(now, toggle_stamp_q) >=
                                timing_q.fault_toggle_half_period) begin
                                reset_bit_q    = !reset_bit_q;
                                toggle_stamp_q = now;
                            end
                            last_cw_q = reset_bit_q ? dsen_pkg::CW_FAULT_RESET
                                                    : dsen_pkg::CW_NEUTRAL;
                        end else if (had_fault_q) begin
                            // Fault gone: hold neutral until the settling time is over.
                            last_cw_q = dsen_pkg::CW_NEUTRAL;
                            if (!settling_q) begin
                                settling_q     = 1'b1;
                                settle_stamp_q = now;
                            end else if (ticks_since(now, settle_stamp_q) >=
                                         timing_q.settle_delay) begin
                                seq_q       = dsen_pkg::SEQ_SAFE_RESET;
                                had_fault_q = 1'b0;
                                settling_q  = 1'b0;
                            end
                        end else begin
                            seq_q = dsen_pkg::SEQ_SAFE_RESET;
                        end
                    end
                    dsen_pkg::SEQ_SAFE_RESET: begin
                        last_cw_q = dsen_pkg::CW_SHUTDOWN;
                        if (ticks_since(now, start_stamp_q) > timing_q.reset_hold_delay) begin
                            seq_q = dsen_pkg::SEQ_PREPARE;
                        end
                    end
                    dsen_pkg::SEQ_PREPARE: begin
                        last_cw_q = dsen_pkg::CW_SHUTDOWN;
                        if (has_bits(req.drive_status, dsen_pkg::ST_READY)) begin
                            seq_q = dsen_pkg::SEQ_SWITCH_ON;
                        end
                    end
                    dsen_pkg::SEQ_SWITCH_ON: begin
                        last_cw_q = dsen_pkg::CW_ENABLE_OP;
                        if (has_bits(req.drive_status, dsen_pkg::ST_ON)) begin
                            seq_q     = dsen_pkg::SEQ_ON;
                            command_q = dsen_pkg::CMD_NONE;
                        end
                    end
                    dsen_pkg::SEQ_FAULT: begin
                        seq_q = dsen_pkg::SEQ_OFF;
                    end
                    default: begin
                    end
                endcase

                // A fault anywhere past OFF, or a sequence that takes too long, restarts it.
                if (seq_q != dsen_pkg::SEQ_OFF && seq_q != dsen_pkg::SEQ_FAULT && faulted) begin
                    seq_q = dsen_pkg::SEQ_OFF;
                end
                if (seq_q != dsen_pkg::SEQ_ON && seq_q != dsen_pkg::SEQ_FAULT &&
                    seq_q != dsen_pkg::SEQ_OFF &&
                    ticks_since(now, start_stamp_q) > timing_q.enable_timeout) begin
                    seq_q = dsen_pkg::SEQ_OFF;
                end
            end
            dsen_pkg::CMD_DISABLE: begin
                last_cw_q = dsen_pkg::CW_DISABLE_V;
                if (has_bits(req.drive_status, dsen_pkg::ST_OFF)) begin
                    seq_q     = dsen_pkg::SEQ_OFF;
                    command_q = dsen_pkg::CMD_NONE;
                end
            end
            default: begin
                if (faulted) begin
                    seq_q = dsen_pkg::SEQ_FAULT;
                end
            end
        endcase

        res.control_word   = last_cw_q;
        res.drive_state    = seq_q;
        res.active_command = command_q;
    endtask

    // ------------------------------------------------------------------
    // Queues and counters shared by the stimulus, the driver and the monitor.
    // ------------------------------------------------------------------
    dsen_pkg::t_in_item  pending_requests[$];
    dsen_pkg::t_out_item expected_drive_out[$];
    int unsigned queued_count    = 0;
    int unsigned accepted_count  = 0;
    int unsigned checked_count   = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    logic        in_taken        = 1'b0;
    logic [31:0] tick_now        = '0;
    int unsigned step_max        = 3;

    // ------------------------------------------------------------------
    // Driver: the sender works in bursts with random gaps in between. A new
    // transaction is offered only once the current one has been accepted.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                i_in_item  <= pending_requests.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // A quarter of the bursts run straight into the next one.
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a style that is picked anew at random after each run.
    // When the stimulus asks for it, ready is held low for a long stretch so
    // that both pipeline registers fill and the input side stalls.
    // ------------------------------------------------------------------
    t_ready_style ready_style  = READY_ALWAYS;
    int unsigned  style_left   = 0;
    int unsigned  stall_phase  = 0;
    int unsigned  hold_left    = 0;
    int unsigned  hold_asks    = 0;
    int unsigned  hold_done    = 0;
    logic         next_ready;

    always @(negedge i_clk) begin
        stall_phase++;
        if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (!i_rst_n) begin
            next_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else begin
            if (style_left == 0) begin
                ready_style = t_ready_style'($urandom_range(0, 3));
                style_left  = $urandom_range(8, 64);
            end
            style_left--;
            case (ready_style)
                READY_ALWAYS:   next_ready = 1'b1;
                READY_COIN:     next_ready = $urandom_range(0, 1);
                READY_SPARSE:   next_ready = ($urandom_range(0, 3) == 0);
                default:        next_ready = (stall_phase % 5) != 0;
            endcase
        end
        i_out_ready <= next_ready;
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted input transaction is run through the model,
    // and every accepted result is checked against the oldest prediction.
    // ------------------------------------------------------------------
    dsen_pkg::t_out_item predicted;
    dsen_pkg::t_out_item oldest;

    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                step_sequencer_model(i_in_item, predicted);
                expected_drive_out.push_back(predicted);
                accepted_count++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_drive_out.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: result with nothing expected: cw=%h state=%0d cmd=%0d",
                                 $time, o_out_item.control_word, o_out_item.drive_state,
                                 o_out_item.active_command);
                    end
                end else begin
                    oldest = expected_drive_out.pop_front();
                    checked_count++;
                    if (o_out_item.control_word !== oldest.control_word ||
                        o_out_item.drive_state !== oldest.drive_state ||
                        o_out_item.active_command !== oldest.active_command) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: result %0d: expected cw=%h state=%0d cmd=%0d,",
                                     $time, checked_count, oldest.control_word,
                                     oldest.drive_state, oldest.active_command,
                                     " got cw=%h state=%0d cmd=%0d",
                                     o_out_item.control_word, o_out_item.drive_state,
                                     o_out_item.active_command);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[ds402_drive_enable_sequencer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Configuration access and stimulus helpers.
    // ------------------------------------------------------------------

    // One APB write followed by a read back of the same register. The model
    // takes the new value at once, since writes happen only while idle.
    task automatic write_timing_reg(input logic [1:0] reg_index, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_index)
            dsen_pkg::REG_FAULT_TOGGLE: timing_q.fault_toggle_half_period = value;
            dsen_pkg::REG_SETTLE:       timing_q.settle_delay             = value;
            dsen_pkg::REG_RESET_HOLD:   timing_q.reset_hold_delay         = value;
            default:                    timing_q.enable_timeout           = value;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: register %0d read back %h, expected %h",
                         $time, reg_index, prdata, value);
            end
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_timing(input logic [31:0] toggle_half, input logic [31:0] settle,
                               input logic [31:0] hold, input logic [31:0] timeout);
        write_timing_reg(dsen_pkg::REG_FAULT_TOGGLE, toggle_half);
        write_timing_reg(dsen_pkg::REG_SETTLE, settle);
        write_timing_reg(dsen_pkg::REG_RESET_HOLD, hold);
        write_timing_reg(dsen_pkg::REG_ENABLE_TMO, timeout);
    endtask

    // Mostly small delays so that sequences complete, now and then a full-range one.
    function automatic logic [31:0] pick_delay(input bit wide);
        if (wide && $urandom_range(0, 2) == 0) begin
            return $urandom;
        end
        return $urandom_range(0, 60);
    endfunction

    // Sender pause: nothing more is offered until every result has come back.
    task automatic drain_results();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_drive_out.size() != 0);
    endtask

    task automatic queue_request_at(input logic [1:0] req_mode, input logic [15:0] sw,
                                    input logic [31:0] stamp);
        dsen_pkg::t_in_item req;
        tick_now         = stamp;
        req.mode         = req_mode;
        req.drive_status = sw;
        req.time_now     = stamp;
        pending_requests.push_back(req);
        queued_count++;
    endtask

    // The timestamp moves on by a few ticks, with a rare large jump that
    // trips timeouts and long toggle periods.
    task automatic queue_request(input logic [1:0] req_mode, input logic [15:0] sw);
        logic [31:0] dt;
        dt = ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, step_max);
        queue_request_at(req_mode, sw, tick_now + dt);
    endtask

    function automatic logic [1:0] enable_or_update();
        return ($urandom_range(0, 3) == 0) ? dsen_pkg::MODE_ENABLE : dsen_pkg::MODE_UPDATE;
    endfunction

    function automatic logic [15:0] with_stray_fault(input logic [15:0] sw);
        return ($urandom_range(0, 24) == 0) ? (sw | dsen_pkg::ST_FAULT) : sw;
    endfunction

    // A well-formed enable episode as a drive would answer it: optional fault
    // acknowledge, fault cleared, ready, operation enabled, then often a
    // disable that the drive eventually confirms.
    task automatic queue_enable_cycle();
        int unsigned n;
        logic [15:0] sw;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        if (n > 0) begin
            queue_request(dsen_pkg::MODE_ENABLE, 16'($urandom) | dsen_pkg::ST_FAULT);
            repeat (n - 1) begin
                queue_request(enable_or_update(), 16'($urandom) | dsen_pkg::ST_FAULT);
            end
        end else begin
            queue_request(dsen_pkg::MODE_ENABLE,
                          16'($urandom) & ~(dsen_pkg::ST_FAULT | dsen_pkg::ST_READY));
        end
        repeat ($urandom_range(1, 12)) begin
            queue_request(enable_or_update(),
                          16'($urandom) & ~(dsen_pkg::ST_FAULT | dsen_pkg::ST_READY));
        end
        repeat ($urandom_range(1, 8)) begin
            sw = (16'($urandom)
                  & ~(dsen_pkg::ST_FAULT | (dsen_pkg::ST_ON ^ dsen_pkg::ST_READY)))
                 | dsen_pkg::ST_READY;
            queue_request(enable_or_update(), with_stray_fault(sw));
        end
        repeat ($urandom_range(1, 6)) begin
            sw = (16'($urandom) & ~dsen_pkg::ST_FAULT) | dsen_pkg::ST_ON;
            queue_request(enable_or_update(), with_stray_fault(sw));
        end
        // Idle updates while on; a fault here moves the sequence to its fault state.
        repeat ($urandom_range(0, 5)) begin
            sw = (16'($urandom) & ~dsen_pkg::ST_FAULT) | dsen_pkg::ST_ON;
            queue_request(dsen_pkg::MODE_UPDATE,
                          ($urandom_range(0, 5) == 0) ? (sw | dsen_pkg::ST_FAULT) : sw);
        end
        if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(0, 4)) begin
                queue_request(dsen_pkg::MODE_DISABLE, 16'($urandom) & ~dsen_pkg::ST_OFF);
            end
            queue_request(($urandom_range(0, 1) == 1) ? dsen_pkg::MODE_DISABLE
                                                      : dsen_pkg::MODE_UPDATE,
                          16'($urandom) | dsen_pkg::ST_OFF);
        end
    endtask

    // Free-form transactions: any mode code, any statusword, sometimes any timestamp.
    task automatic queue_noise();
        if ($urandom_range(0, 3) == 0) begin
            queue_request_at(2'($urandom_range(0, 3)), 16'($urandom), $urandom);
        end else begin
            queue_request(2'($urandom_range(0, 3)), 16'($urandom));
        end
    endtask

    task automatic run_random_phase(input int unsigned count);
        int unsigned start;
        start = queued_count;
        while (queued_count - start < count) begin
            if ($urandom_range(0, 6) == 0) begin
                queue_noise();
            end else begin
                queue_enable_cycle();
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        // Model state after reset; the block's registers come up at these values.
        command_q      = dsen_pkg::CMD_NONE;
        seq_q          = dsen_pkg::SEQ_OFF;
        had_fault_q    = 1'b0;
        settling_q     = 1'b0;
        reset_bit_q    = 1'b0;
        start_stamp_q  = '0;
        toggle_stamp_q = '0;
        settle_stamp_q = '0;
        last_cw_q      = '0;
        timing_q.fault_toggle_half_period = dsen_pkg::RST_FAULT_TOGGLE;
        timing_q.settle_delay             = dsen_pkg::RST_SETTLE;
        timing_q.reset_hold_delay         = dsen_pkg::RST_RESET_HOLD;
        timing_q.enable_timeout           = dsen_pkg::RST_ENABLE_TMO;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset timing. An update with no command,
        // then the reserved mode code with a faulted drive, which parks the
        // sequence in its fault state.
        queue_request_at(dsen_pkg::MODE_UPDATE, 16'h0000, 32'h0000_0000);
        queue_request_at(MODE_RESERVED, 16'hFFFF, 32'hFFFF_FFFF);
        // Enable from the fault state drops to off, then the fault reset bit
        // toggles on and off at the half period while the drive stays faulted.
        queue_request_at(dsen_pkg::MODE_ENABLE, dsen_pkg::ST_FAULT, 32'd100);
        queue_request_at(dsen_pkg::MODE_ENABLE, dsen_pkg::ST_FAULT, 32'd60000);
        queue_request_at(dsen_pkg::MODE_UPDATE, dsen_pkg::ST_FAULT, 32'd70000);
        queue_request_at(dsen_pkg::MODE_UPDATE, dsen_pkg::ST_FAULT, 32'd110000);
        // Fault cleared: settling starts, and after the delay the shutdown hold.
        queue_request_at(dsen_pkg::MODE_UPDATE, 16'h0000, 32'd120000);
        queue_request_at(dsen_pkg::MODE_UPDATE, 16'h0000, 32'd230000);
        queue_request_at(dsen_pkg::MODE_UPDATE, 16'h0000, 32'd235000);
        queue_request_at(dsen_pkg::MODE_UPDATE, 16'h0000, 32'd241000);
        // Ready, switch on, operation enabled; enable while on repeats the word.
        queue_request_at(dsen_pkg::MODE_UPDATE, dsen_pkg::ST_READY, 32'd242000);
        queue_request_at(dsen_pkg::MODE_UPDATE, dsen_pkg::ST_READY, 32'd243000);
        queue_request_at(dsen_pkg::MODE_UPDATE, dsen_pkg::ST_ON, 32'd244000);
        queue_request_at(dsen_pkg::MODE_ENABLE, dsen_pkg::ST_ON, 32'd245000);
        // Disable holds disable voltage until the drive reports it is off.
        queue_request_at(dsen_pkg::MODE_DISABLE, dsen_pkg::ST_ON, 32'd246000);
        queue_request_at(dsen_pkg::MODE_DISABLE, dsen_pkg::ST_OFF, 32'd247000);
        // A clean enable across the timestamp wrap, then a fault while preparing.
        queue_request_at(dsen_pkg::MODE_ENABLE, 16'h0000, 32'hFFFF_FF00);
        queue_request_at(dsen_pkg::MODE_UPDATE, 16'h0000, 32'h0000_3000);
        queue_request_at(dsen_pkg::MODE_UPDATE, dsen_pkg::ST_READY | dsen_pkg::ST_FAULT,
                         32'h0000_3100);
        // An enable that runs past the timeout restarts from off.
        queue_request_at(dsen_pkg::MODE_ENABLE, 16'h0000, 32'h0000_4000);
        queue_request_at(dsen_pkg::MODE_UPDATE, 16'h0000, 32'h0000_4000 + 32'd2000000);
        // Disable that completes on a later update-only transaction.
        queue_request_at(dsen_pkg::MODE_DISABLE, 16'h0000, 32'h0020_0000);
        queue_request_at(dsen_pkg::MODE_UPDATE, dsen_pkg::ST_OFF, 32'h0020_0010);
        queue_request_at(dsen_pkg::MODE_UPDATE, 16'h0000, 32'h0020_0020);
        drain_results();

        // Short delays so that full enable sequences fit between timeouts,
        // with a sender pause halfway through.
        step_max = 3;
        load_timing(32'd5, 32'd12, 32'd4, 32'd80);
        run_random_phase(150);
        run_random_phase(150);

        // All delays at zero.
        step_max = 2;
        load_timing('0, '0, '0, '0);
        run_random_phase(200);

        // All delays at their maximum, with the timestamp about to wrap.
        step_max = 4;
        tick_now = 32'hFFFF_FF80;
        load_timing('1, '1, '1, '1);
        run_random_phase(150);

        // Random small delays; the receiver holds off for a long stretch
        // while the sender keeps offering transactions.
        step_max = 6;
        load_timing(pick_delay(1'b0), pick_delay(1'b0), pick_delay(1'b0), pick_delay(1'b0));
        hold_asks++;
        run_random_phase(300);

        // Random delays, some of them full range.
        step_max = 8;
        load_timing(pick_delay(1'b1), pick_delay(1'b1), pick_delay(1'b1), pick_delay(1'b1));
        run_random_phase(300);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_drive_out.size() != 0) begin
            mismatch_count++;
        end

        $display("Checked %0d results for %0d transactions under six timing settings,",
                 checked_count, accepted_count);
        $display("covering fault reset, settling, timeouts, disable and timestamp wrap.");
        if (mismatch_count == 0) begin
            $display("[ds402_drive_enable_sequencer] OK");
        end else begin
            $display("[ds402_drive_enable_sequencer] ERROR");
        end
        $finish;
    end

endmodule
